/* design/refcounted_slot_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Immediate-consequence and next-cycle property wrappers, compiled out for
// synthesis. The properties sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");
`define RSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");
`else
`define RSA_ASSERT_NOW(label, ante, cons)
`define RSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// Slot allocator package
// Request and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int SLOT_COUNT_DEF  = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SLOT_FIELD_W    = 8;
    localparam int INDEX_OUT_W     = 8;
    localparam int COUNT_OUT_W     = 16;
    localparam int SEARCH_GROUP    = 16;
    localparam int SEARCH_GROUP_W  = 4;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RETAIN  = 2'd1,
        REQ_RELEASE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FREE = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

endpackage

/* design/rsa_free_search.sv */
// ----------------------------------------------------------------------------
// Lowest free slot search
// Two-level priority encoder: the lowest free slot inside each group of
// slots, then the lowest group that has a free slot.
// ----------------------------------------------------------------------------
module rsa_free_search #(
    parameter int SLOT_COUNT = 256
) (
    input  logic [SLOT_COUNT-1:0]         busy,
    output logic                          found,
    output logic [$clog2(SLOT_COUNT)-1:0] index
);
    import rsa_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int NG = (SLOT_COUNT + SEARCH_GROUP - 1) / SEARCH_GROUP;
    localparam int PW = NG * SEARCH_GROUP;
    localparam int IW = $clog2(PW);

    logic [PW-1:0]             free_pad;
    logic [NG-1:0]             grp_any;
    logic [SEARCH_GROUP_W-1:0] grp_low [NG];
    logic [IW-1:0]             full_index;

    assign free_pad = {{(PW - SLOT_COUNT){1'b0}}, ~busy};

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any[g] = |free_pad[g*SEARCH_GROUP +: SEARCH_GROUP];
            grp_low[g] = '0;
            for (int b = SEARCH_GROUP - 1; b >= 0; b--)
            begin
                if (free_pad[g*SEARCH_GROUP + b])
                begin
                    grp_low[g] = SEARCH_GROUP_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        found      = 1'b0;
        full_index = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                found      = 1'b1;
                full_index = IW'(g * SEARCH_GROUP + int'(grp_low[g]));
            end
        end
    end

    assign index = full_index[SW-1:0];

endmodule

/* design/rsa_count_mem.sv */
// ----------------------------------------------------------------------------
// Reference count memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_count_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/refcounted_slot_allocator.sv */
// ----------------------------------------------------------------------------
// Reference-counted slot allocator
// A table of slots with in-use marks and reference counts, driven by
// allocate, retain and release requests, one result per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ channel: s_tuser carries the request type and
// s_tdata the slot number. Each request yields exactly one result on the m_
// channel: m_tuser carries the status, m_tdata the slot index, the freed flag
// and the count after the request.
// A request is registered on acceptance together with the count memory read
// of its slot, and is resolved when it moves into the output register.
// Unless the receiver stalls, one request is accepted every cycle; a write
// to a count in the cycle its slot is read is forwarded, so back-to-back
// requests on one slot are exact. Allocation takes the lowest free slot
// found by a priority encoder over the in-use flip-flops.
// Reset clears every in-use mark at once; counts are only used for slots in
// use. When the receiver stalls, the output register holds its result, one
// more request waits in the input register, and s_tready then drops.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator #(
    parameter int SLOT_COUNT  = rsa_pkg::SLOT_COUNT_DEF,
    parameter int COUNT_WIDTH = rsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] slot
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] slot_index, [8] freed, [24:9] count_after
    output logic [1:0]  m_tuser    // [1:0] status
);
    import rsa_pkg::*;

    `include "refcounted_slot_allocator_macros.svh"

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] COUNT_ONE = CW'(1);

    logic [SLOT_COUNT-1:0]   busy_reg;
    logic [SLOT_COUNT-1:0]   busy_next;
    logic                    s1_valid_reg;
    req_t                    s1_req_reg;
    logic [SLOT_FIELD_W-1:0] s1_slot_reg;
    logic                    byp_hit_reg;
    logic                    byp_hit_next;
    logic [CW-1:0]           byp_data_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic [INDEX_OUT_W-1:0]  out_index_reg;
    logic [INDEX_OUT_W-1:0]  out_index_next;
    logic                    out_freed_reg;
    logic                    out_freed_next;
    logic [COUNT_OUT_W-1:0]  out_count_reg;
    logic [COUNT_OUT_W-1:0]  out_count_next;

    logic                    s_accept;
    logic                    adv;
    logic [SW+SLOT_FIELD_W-1:0] in_slot_wide;
    logic [SW+SLOT_FIELD_W-1:0] s1_slot_wide;
    logic [SW-1:0]           rd_addr;
    logic [SW-1:0]           s1_addr;
    logic                    s1_in_range;
    logic                    s1_busy;
    logic [CW-1:0]           rd_data;
    logic [CW-1:0]           cnt_cur;
    logic [CW-1:0]           cnt_inc;
    logic [CW-1:0]           cnt_dec;
    logic                    found;
    logic [SW-1:0]           free_idx;
    logic [SW+INDEX_OUT_W-1:0] free_idx_wide;
    logic [CW+COUNT_OUT_W-1:0] cnt_inc_wide;
    logic [CW+COUNT_OUT_W-1:0] cnt_dec_wide;
    logic [CW+COUNT_OUT_W-1:0] cnt_max_wide;
    logic                    wr_en;
    logic [SW-1:0]           wr_addr;
    logic [CW-1:0]           wr_data;
    logic                    set_en;
    logic                    clr_en;

    assign s_accept = s_tvalid && s_tready;
    assign adv      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;

    assign in_slot_wide = {{SW{1'b0}}, s_tdata};
    assign rd_addr      = in_slot_wide[SW-1:0];
    assign s1_slot_wide = {{SW{1'b0}}, s1_slot_reg};
    assign s1_addr      = s1_slot_wide[SW-1:0];
    assign s1_in_range  = int'(s1_slot_reg) < SLOT_COUNT;
    assign s1_busy      = s1_in_range && busy_reg[s1_addr];

    assign cnt_cur = byp_hit_reg ? byp_data_reg : rd_data;
    assign cnt_inc = cnt_cur + COUNT_ONE;
    assign cnt_dec = cnt_cur - COUNT_ONE;

    assign free_idx_wide = {{INDEX_OUT_W{1'b0}}, free_idx};
    assign cnt_inc_wide  = {{COUNT_OUT_W{1'b0}}, cnt_inc};
    assign cnt_dec_wide  = {{COUNT_OUT_W{1'b0}}, cnt_dec};
    assign cnt_max_wide  = {{COUNT_OUT_W{1'b0}}, COUNT_MAX};

    rsa_free_search #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_search (
        .busy  (busy_reg),
        .found (found),
        .index (free_idx)
    );

    rsa_count_mem #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (CW)
    ) u_counts (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en && adv),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = s1_addr;
        wr_data         = cnt_cur;
        set_en          = 1'b0;
        clr_en          = 1'b0;
        out_status_next = ST_OK;
        out_index_next  = s1_slot_reg;
        out_freed_next  = 1'b0;
        out_count_next  = '0;
        case (s1_req_reg)
            REQ_ALLOC:
            begin
                if (found)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = free_idx;
                    wr_data        = COUNT_ONE;
                    set_en         = 1'b1;
                    out_index_next = free_idx_wide[INDEX_OUT_W-1:0];
                    out_count_next = COUNT_OUT_W'(1);
                end
                else
                begin
                    out_status_next = ST_FULL;
                    out_index_next  = '0;
                end
            end
            REQ_RETAIN:
            begin
                if (!s1_busy)
                begin
                    out_status_next = ST_FREE;
                end
                else if (cnt_cur == COUNT_MAX)
                begin
                    out_status_next = ST_SAT;
                    out_count_next  = cnt_max_wide[COUNT_OUT_W-1:0];
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = cnt_inc;
                    out_count_next = cnt_inc_wide[COUNT_OUT_W-1:0];
                end
            end
            REQ_RELEASE:
            begin
                if (!s1_busy)
                begin
                    out_status_next = ST_FREE;
                end
                else if (cnt_cur <= COUNT_ONE)
                begin
                    wr_en          = 1'b1;
                    wr_data        = '0;
                    clr_en         = 1'b1;
                    out_freed_next = 1'b1;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = cnt_dec;
                    out_count_next = cnt_dec_wide[COUNT_OUT_W-1:0];
                end
            end
            default:
            begin
                out_status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (adv && set_en)
        begin
            busy_next[free_idx] = 1'b1;
        end
        if (adv && clr_en)
        begin
            busy_next[s1_addr] = 1'b0;
        end
    end

    assign byp_hit_next = s_accept && adv && wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s_accept)
            begin
                byp_hit_reg <= byp_hit_next;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_req_reg   <= req_t'(s_tuser);
            s1_slot_reg  <= s_tdata;
            byp_data_reg <= wr_data;
        end
        if (adv)
        begin
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
            out_freed_reg  <= out_freed_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_freed_reg, out_index_reg};

    `RSA_ASSERT_NEXT(a_alloc_marks_busy, adv && set_en, busy_reg[$past(free_idx)])
    `RSA_ASSERT_NEXT(a_release_frees, adv && clr_en, !busy_reg[$past(s1_addr)])
    `RSA_ASSERT_NOW(a_freed_zero, out_valid_reg && out_freed_reg,
        out_status_reg == ST_OK && out_count_reg == '0)
    `RSA_ASSERT_NOW(a_sat_at_max, out_valid_reg && out_status_reg == ST_SAT,
        out_count_reg == cnt_max_wide[COUNT_OUT_W-1:0])

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the reference-counted slot allocator
// Drives allocate, retain and release requests into the stream input and
// predicts each result from a private copy of the slot table. The run starts
// with a table of directed requests: free-slot errors, freeing on the last
// release, table full and the unused request type. Random traffic follows,
// with idling on both sides and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rsa_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 50;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot_index;
        logic        freed;
        logic [15:0] count_after;
    } alloc_result_t;

    typedef struct {
        logic [1:0]    kind;
        logic [7:0]    slot;
        int            reps;
        bit            typed;
        alloc_result_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    logic          slot_live [SLOTS];
    logic [15:0]   slot_refs [SLOTS];
    alloc_result_t awaited_results [$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;

    plan_row_t plan [17] = '{
        '{REQ_RETAIN,  8'd0,   1,     1'b1, '{ST_FREE, 8'd0,   1'b0, 16'd0}},
        '{REQ_RELEASE, 8'd255, 1,     1'b1, '{ST_FREE, 8'd255, 1'b0, 16'd0}},
        '{REQ_UNUSED,  8'hAA,  1,     1'b1, '{ST_OK,   8'hAA,  1'b0, 16'd0}},
        '{REQ_ALLOC,   8'd0,   1,     1'b1, '{ST_OK,   8'd0,   1'b0, 16'd1}},
        '{REQ_ALLOC,   8'h5C,  1,     1'b1, '{ST_OK,   8'd1,   1'b0, 16'd1}},
        '{REQ_RETAIN,  8'd0,   1,     1'b0, '0},
        '{REQ_RELEASE, 8'd0,   1,     1'b0, '0},
        '{REQ_RELEASE, 8'd0,   1,     1'b1, '{ST_OK,   8'd0,   1'b1, 16'd0}},
        '{REQ_RELEASE, 8'd0,   1,     1'b1, '{ST_FREE, 8'd0,   1'b0, 16'd0}},
        '{REQ_ALLOC,   8'hFF,  1,     1'b1, '{ST_OK,   8'd0,   1'b0, 16'd1}},
        '{REQ_RELEASE, 8'd1,   1,     1'b1, '{ST_OK,   8'd1,   1'b1, 16'd0}},
        '{REQ_RETAIN,  8'd1,   1,     1'b1, '{ST_FREE, 8'd1,   1'b0, 16'd0}},
        '{REQ_ALLOC,   8'd0,   255,   1'b0, '0},
        '{REQ_ALLOC,   8'd0,   1,     1'b1, '{ST_FULL, 8'd0,   1'b0, 16'd0}},
        '{REQ_UNUSED,  8'hFF,  1,     1'b1, '{ST_OK,   8'hFF,  1'b0, 16'd0}},
        '{REQ_RELEASE, 8'd255, 1,     1'b1, '{ST_OK,   8'd255, 1'b1, 16'd0}},
        '{REQ_ALLOC,   8'd7,   1,     1'b1, '{ST_OK,   8'd255, 1'b0, 16'd1}}
    };

    refcounted_slot_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic alloc_result_t resolve_request(input logic [1:0] kind,
                                                      input logic [7:0] slot);
        alloc_result_t r;
        int lowest_free;
        r = '{ST_OK, slot, 1'b0, 16'd0};
        lowest_free = -1;
        case (kind)
            REQ_ALLOC:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!slot_live[i])
                        lowest_free = i;
                end
                if (lowest_free < 0)
                    r = '{ST_FULL, 8'd0, 1'b0, 16'd0};
                else
                begin
                    slot_live[lowest_free] = 1'b1;
                    slot_refs[lowest_free] = 16'd1;
                    r = '{ST_OK, lowest_free[7:0], 1'b0, 16'd1};
                end
            end
            REQ_RETAIN:
            begin
                if (!slot_live[slot])
                    r.status = ST_FREE;
                else if (slot_refs[slot] == 16'hFFFF)
                begin
                    r.status = ST_SAT;
                    r.count_after = 16'hFFFF;
                end
                else
                begin
                    slot_refs[slot] = slot_refs[slot] + 16'd1;
                    r.count_after = slot_refs[slot];
                end
            end
            REQ_RELEASE:
            begin
                if (!slot_live[slot])
                    r.status = ST_FREE;
                else if (slot_refs[slot] <= 16'd1)
                begin
                    slot_refs[slot] = 16'd0;
                    slot_live[slot] = 1'b0;
                    r.freed = 1'b1;
                end
                else
                begin
                    slot_refs[slot] = slot_refs[slot] - 16'd1;
                    r.count_after = slot_refs[slot];
                end
            end
            default:
            begin
                r = '{ST_OK, slot, 1'b0, 16'd0};
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
        mismatches++;
    endtask

    // Starts and ends on a rising edge; the request is accepted at the last one.
    task automatic send_req(input logic [1:0] kind, input logic [7:0] slot,
                            input bit typed, input alloc_result_t want);
        alloc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= slot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = resolve_request(kind, slot);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Most requests name a live slot so that counts climb and slots get freed;
    // the rest are noise over every slot and every request type.
    task automatic run_random(input int requests, input int tx_idle, input int rx_idle,
                              input bit squeeze);
        logic [1:0] kind;
        logic [7:0] slot;
        logic [7:0] probe;
        int pick;
        bit found;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        if (squeeze)
            hold_asked++;
        for (int n = 0; n < requests; n++)
        begin
            pick = $urandom_range(99);
            slot = 8'($urandom_range(255));
            if (pick < 25)
                kind = REQ_ALLOC;
            else if (pick < 85)
            begin
                kind = (pick < 50) ? REQ_RETAIN : REQ_RELEASE;
                found = 1'b0;
                for (int k = 0; k < SLOTS; k++)
                begin
                    probe = slot + k[7:0];
                    if (!found && slot_live[probe])
                    begin
                        found = 1'b1;
                        slot = probe;
                    end
                end
            end
            else
                kind = 2'($urandom_range(3));
            send_req(kind, slot, 1'b0, '0);
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_asked != hold_taken)
        begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
                note_mismatch("unexpected result", 32'd0, m_tdata);
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[7:0] !== want.slot_index)
                    note_mismatch("slot_index", 32'(want.slot_index), 32'(m_tdata[7:0]));
                if (m_tdata[8] !== want.freed)
                    note_mismatch("freed", 32'(want.freed), 32'(m_tdata[8]));
                if (m_tdata[24:9] !== want.count_after)
                    note_mismatch("count_after", 32'(want.count_after),
                                  32'(m_tdata[24:9]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_refs[i] = 16'd0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].reps; k++)
                send_req(plan[r].kind, plan[r].slot, plan[r].typed, plan[r].want);
        end
        wait_drained();

        run_random(190, 19, 70, 1'b0);
        run_random(190, 70, 19, 1'b0);
        run_random(200, 0, 0, 1'b1);

        repeat (10) @(posedge clk);
        if (awaited_results.size() != 0)
            note_mismatch("results still awaited", 32'd0, 32'(awaited_results.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
